>>> rtl/wlh_pkg.sv
// shared types, constants and helpers for the word length histogram
`default_nettype none

package wlh_pkg;

    localparam int CNT_W = 32;

    localparam logic [7:0] SEP_SPACE   = 8'h20;
    localparam logic [7:0] SEP_TAB     = 8'h09;
    localparam logic [7:0] SEP_NEWLINE = 8'h0A;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0]
    {
        REQ_TEXT = 2'd0,
        REQ_END  = 2'd1,
        REQ_READ = 2'd2
    } req_type_t;

    // per-word control handed from the front stage to the update stage
    typedef struct packed
    {
        logic             inc;
        logic             rd;
        logic             in_range;
        logic [CNT_W-1:0] words_total;
    } item_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/word_length_histogram_top.sv
// top level of the word length histogram
//
// channel   dir  tdata                                   tuser
// s_axis    in   [7:0] data_byte, [14:8] bin_index       [1:0] req_type
// m_axis    out  [31:0] words_total, [63:32] bin_count   read_flag
//
// one word accepted per cycle unless stalled; results pass the update and output registers
// bin counts sit in one ram; a bin update reads in the cycle of acceptance and
// writes when its word leaves the update stage, a bypass register covers back-to-back hits
// after reset a clear sweep writes zero to every bin, with s_axis_tready low throughout
// a stalled m_axis holds one result in the output register and one in the update stage
`default_nettype none

module word_length_histogram_top #(
    parameter int NUM_BINS = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // data_byte, bin_index, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // words_total, bin_count
    output logic             m_axis_tuser    // read_flag
);

    localparam int AW = $clog2(NUM_BINS);

    logic                       acc;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    wlh_pkg::item_t             item;
    logic                       clr_busy;
    logic [AW-1:0]              clr_addr;
    logic [wlh_pkg::CNT_W-1:0]  rd_data;
    logic                       upd_we;
    logic [AW-1:0]              upd_addr;
    logic [wlh_pkg::CNT_W-1:0]  upd_data;
    logic                       upd_ready;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [wlh_pkg::CNT_W-1:0]  ram_wdata;
    logic [wlh_pkg::CNT_W-1:0]  out_total;
    logic [wlh_pkg::CNT_W-1:0]  out_count;

    assign s_axis_tready = !clr_busy && upd_ready;
    assign acc           = s_axis_tvalid && s_axis_tready;

    wlh_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .req_type  (s_axis_tuser),
        .data_byte (s_axis_tdata[7:0]),
        .bin_index (s_axis_tdata[14:8]),
        .re        (rd_en),
        .raddr     (rd_addr),
        .item      (item),
        .clr_busy  (clr_busy),
        .clr_addr  (clr_addr)
    );

    assign ram_we    = clr_busy || upd_we;
    assign ram_waddr = clr_busy ? clr_addr : upd_addr;
    assign ram_wdata = clr_busy ? '0 : upd_data;

    wlh_ram #(
        .WIDTH (wlh_pkg::CNT_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    wlh_update #(
        .NUM_BINS (NUM_BINS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .item      (item),
        .addr      (rd_addr),
        .rdata     (rd_data),
        .we        (upd_we),
        .waddr     (upd_addr),
        .wdata     (upd_data),
        .ready     (upd_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_total (out_total),
        .out_count (out_count),
        .out_flag  (m_axis_tuser)
    );

    assign m_axis_tdata = {out_count, out_total};

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_axis_tready)
        else $error("word accepted during clear sweep");

    a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !upd_we)
        else $error("bin update during clear sweep");

    a_count_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[63:32] == '0))
        else $error("bin count on a non-read result");

endmodule

`default_nettype wire

>>> rtl/wlh_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module wlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/wlh_front.sv
// front stage: word length tracking, total count, bin lookup and clear sweep
`default_nettype none

module wlh_front #(
    parameter int NUM_BINS = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        acc,
    input  wire logic [1:0]                  req_type,
    input  wire logic [7:0]                  data_byte,
    input  wire logic [6:0]                  bin_index,
    output logic                             re,
    output logic [$clog2(NUM_BINS)-1:0]      raddr,
    output wlh_pkg::item_t                   item,
    output logic                             clr_busy,
    output logic [$clog2(NUM_BINS)-1:0]      clr_addr
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [AW-1:0] TOP_BIN = AW'(NUM_BINS - 1);

    logic [AW-1:0]               len_reg,   len_next;
    logic [wlh_pkg::CNT_W-1:0]   tally_reg, tally_next;
    logic                        clr_busy_reg, clr_busy_next;
    logic [AW-1:0]               clr_addr_reg, clr_addr_next;
    logic                        is_sep;
    logic                        closes;
    logic                        is_read;
    logic                        in_range;

    always_comb
    begin
        is_sep   = (data_byte == wlh_pkg::SEP_SPACE) || (data_byte == wlh_pkg::SEP_TAB)
                   || (data_byte == wlh_pkg::SEP_NEWLINE);
        closes   = 1'b0;
        is_read  = 1'b0;
        in_range = (32'(bin_index) < NUM_BINS);
        len_next = len_reg;

        unique case (wlh_pkg::req_type_t'(req_type))
            wlh_pkg::REQ_TEXT:
            begin
                if (is_sep)
                begin
                    closes = 1'b1;
                end
                else if (len_reg != TOP_BIN)
                begin
                    len_next = len_reg + AW'(1);
                end
            end
            wlh_pkg::REQ_END:  closes  = 1'b1;
            wlh_pkg::REQ_READ: is_read = 1'b1;
            default: ;
        endcase

        if (closes)
        begin
            len_next = '0;
        end
        if (!acc)
        begin
            len_next = len_reg;
        end

        tally_next = tally_reg;
        if (acc && closes && (len_reg != '0))
        begin
            tally_next = wlh_pkg::sat_inc(tally_reg);
        end

        item.inc         = closes && (len_reg != '0);
        item.rd          = is_read;
        item.in_range    = in_range;
        item.words_total = tally_next;

        re    = acc && (item.inc || (is_read && in_range));
        raddr = item.inc ? len_reg : AW'(bin_index);

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == TOP_BIN)
            begin
                clr_busy_next = 1'b0;
                clr_addr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            tally_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            len_reg      <= len_next;
            tally_reg    <= tally_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign clr_busy = clr_busy_reg;
    assign clr_addr = clr_addr_reg;

endmodule

`default_nettype wire

>>> rtl/wlh_update.sv
// update stage: bin increment with write forwarding, and output register
`default_nettype none

module wlh_update #(
    parameter int NUM_BINS = 128
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             acc,
    input  wire wlh_pkg::item_t                   item,
    input  wire logic [$clog2(NUM_BINS)-1:0]      addr,
    input  wire logic [wlh_pkg::CNT_W-1:0]        rdata,
    output logic                                  we,
    output logic [$clog2(NUM_BINS)-1:0]           waddr,
    output logic [wlh_pkg::CNT_W-1:0]             wdata,
    output logic                                  ready,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [wlh_pkg::CNT_W-1:0]             out_total,
    output logic [wlh_pkg::CNT_W-1:0]             out_count,
    output logic                                  out_flag
);

    localparam int AW = $clog2(NUM_BINS);

    logic                       s1_vld_reg, s1_vld_next;
    wlh_pkg::item_t             s1_item_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic                       byp_vld_reg, byp_vld_next;
    logic [AW-1:0]              byp_addr_reg;
    logic [wlh_pkg::CNT_W-1:0]  byp_data_reg;
    logic                       out_vld_reg, out_vld_next;
    logic [wlh_pkg::CNT_W-1:0]  out_total_reg;
    logic [wlh_pkg::CNT_W-1:0]  out_count_reg;
    logic                       out_flag_reg;
    logic                       s1_adv;
    logic [wlh_pkg::CNT_W-1:0]  cur;

    always_comb
    begin
        s1_adv = s1_vld_reg && (!out_vld_reg || out_ready);
        ready  = !s1_vld_reg || !out_vld_reg || out_ready;

        // last write may not be visible yet in the ram read data
        cur = (byp_vld_reg && (byp_addr_reg == s1_addr_reg)) ? byp_data_reg : rdata;

        we    = s1_adv && s1_item_reg.inc;
        waddr = s1_addr_reg;
        wdata = wlh_pkg::sat_inc(cur);

        s1_vld_next  = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);
        byp_vld_next = byp_vld_reg || we;
        out_vld_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            byp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            byp_vld_reg <= byp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_item_reg <= item;
            s1_addr_reg <= addr;
        end
        if (we)
        begin
            byp_addr_reg <= waddr;
            byp_data_reg <= wdata;
        end
        if (s1_adv)
        begin
            out_total_reg <= s1_item_reg.words_total;
            out_count_reg <= (s1_item_reg.rd && s1_item_reg.in_range) ? cur : '0;
            out_flag_reg  <= s1_item_reg.rd;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_total = out_total_reg;
    assign out_count = out_count_reg;
    assign out_flag  = out_flag_reg;

endmodule

`default_nettype wire
